@@ rtl/core/gpid_pkg.sv @@
// ----------------------------------------------------------------------------
// gpid_pkg
// Shared types, constants, gain table and microcode fields for the
// gain-scheduled PID steering block.
// ----------------------------------------------------------------------------
package gpid_pkg;

    // Field and register widths.
    localparam int BRIGHT_W    = 7;
    localparam int SPEED_W     = 8;
    localparam int TURN_W      = 8;
    localparam int THRESH_W    = 7;
    localparam int DTIME_W     = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    // Number of gain entries and the width of a gain key.
    localparam int GAIN_ENTRIES = 5;
    localparam int KEY_W        = (GAIN_ENTRIES > 1) ? $clog2(GAIN_ENTRIES) : 1;

    // Datapath widths.
    localparam int SUM_W    = 24;
    localparam int ERR_W    = 8;
    localparam int DIFF_W   = 9;
    localparam int GAIN_W   = 24;
    localparam int DTPROD_W = 25;
    localparam int MUL_A_W  = 26;
    localparam int MUL_B_W  = 25;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int ACC_W    = 64;
    localparam int INNER_W  = 42;
    localparam int LO_W     = 21;

    // Scaling constants.
    localparam int ERR_SHIFT  = 16;
    localparam int FRAC_SHIFT = 32;
    localparam int DSCALE     = 64000;   // 250 * 256: 1/0.004 in Q.16 with td in Q8.8
    localparam int TURN_LIMIT = 100;
    localparam int SPEED_BASE = 60;
    localparam int SPEED_STEP = 10;
    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(50);

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LINE_THRESHOLD,
        REG_DERIVATIVE_TIME
    } cfg_reg_t;

    // One gain entry: kp and ki = 0.004/ti, both unsigned Q8.16.
    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
    } gain_t;

    // Multiplier operand selects.
    typedef enum logic [2:0] {
        MA_NONE,
        MA_SUM,
        MA_DIFF,
        MA_PROD,
        MA_HI,
        MA_LO
    } mul_a_sel_t;

    typedef enum logic [1:0] {
        MB_KI,
        MB_DTIME,
        MB_DSCALE,
        MB_KP
    } mul_b_sel_t;

    // Accumulator operations.
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD_ERR,
        ACC_ADD_PROD,
        ACC_LOAD_SHIFT
    } acc_op_t;

    // Jump conditions of the sequencer.
    typedef enum logic [1:0] {
        J_NEXT,
        J_NO_ITEM,
        J_OUT_BUSY
    } jump_t;

    // Program steps.
    typedef enum logic [3:0] {
        ST_WAIT,
        ST_UPDATE,
        ST_MUL_KI,
        ST_MUL_DT,
        ST_MUL_SCALE,
        ST_ADD_D,
        ST_MUL_HI,
        ST_MUL_LO,
        ST_ADD_LO,
        ST_OUT
    } step_t;

    // Control word that drives the datapath.
    typedef struct packed {
        logic       accept;
        logic       update;
        logic       mul_en;
        mul_a_sel_t mul_a;
        mul_b_sel_t mul_b;
        acc_op_t    acc_op;
        logic       out_load;
    } ctrl_t;

    // Full microcode word.
    typedef struct packed {
        ctrl_t ctrl;
        jump_t jump;
        step_t target;
    } uword_t;

    // Handshake status seen by the sequencer.
    typedef struct packed {
        logic item_valid;
        logic out_busy;
    } status_t;

    // Speed to gain key: (speed - 60) / 10 truncated toward zero, with
    // anything outside the table falling back to entry 0.
    function automatic logic [KEY_W-1:0] gain_select(logic signed [SPEED_W-1:0] speed);
        logic [KEY_W-1:0] key;
        key = '0;
        for (int i = 1; i < GAIN_ENTRIES; i++) begin
            if (int'(speed) >= SPEED_BASE + SPEED_STEP * i &&
                int'(speed) < SPEED_BASE + SPEED_STEP * (i + 1)) begin
                key = KEY_W'(i);
            end
        end
        return key;
    endfunction

    // Fixed gain table; entries past the fifth hold zero gains.
    function automatic gain_t gain_lookup(logic [KEY_W-1:0] key);
        gain_t g;
        g = '0;
        case (int'(key))
            0: g = '{kp: GAIN_W'(183501), ki: GAIN_W'(590)};
            1: g = '{kp: GAIN_W'(98304),  ki: GAIN_W'(446)};
            2: g = '{kp: GAIN_W'(131072), ki: GAIN_W'(397)};
            3: g = '{kp: GAIN_W'(111411), ki: GAIN_W'(358)};
            4: g = '{kp: GAIN_W'(78643),  ki: GAIN_W'(331)};
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

@@ rtl/core/gpid_if.sv @@
// ----------------------------------------------------------------------------
// gpid_if
// Valid/ready channels of the steering block: sensor words in, turn words out.
// ----------------------------------------------------------------------------
interface gpid_sample_if import gpid_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [BRIGHT_W-1:0]        brightness;
    logic signed [SPEED_W-1:0]  forward_speed;

    modport source (output valid, output brightness, output forward_speed, input ready);
    modport sink   (input valid, input brightness, input forward_speed, output ready);
endinterface

interface gpid_turn_if import gpid_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [TURN_W-1:0]  turn;

    modport source (output valid, output turn, input ready);
    modport sink   (input valid, input turn, output ready);
endinterface

@@ rtl/core/gpid_sequencer.sv @@
// ----------------------------------------------------------------------------
// gpid_sequencer
// Step counter and microcode ROM. Each step issues one control word to the
// datapath; the wait and output steps hold on handshake conditions.
// ----------------------------------------------------------------------------
module gpid_sequencer import gpid_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  status_t status,
    output ctrl_t   ctrl
);

    step_t  step_reg;
    step_t  step_next;
    step_t  step_inc;
    uword_t uword;

    // Microcode program.
    function automatic uword_t ucode(step_t s);
        uword_t w;
        w = '{ctrl: '{accept: 1'b0, update: 1'b0, mul_en: 1'b0, mul_a: MA_NONE,
                      mul_b: MB_KI, acc_op: ACC_HOLD, out_load: 1'b0},
              jump: J_NEXT, target: ST_WAIT};
        unique case (s)
            ST_WAIT:
            begin
                w.ctrl.accept = 1'b1;
                w.jump        = J_NO_ITEM;
                w.target      = ST_WAIT;
            end
            ST_UPDATE:
            begin
                w.ctrl.update = 1'b1;
            end
            ST_MUL_KI:
            begin
                w.ctrl.mul_en = 1'b1;
                w.ctrl.mul_a  = MA_SUM;
                w.ctrl.mul_b  = MB_KI;
                w.ctrl.acc_op = ACC_LOAD_ERR;
            end
            ST_MUL_DT:
            begin
                w.ctrl.mul_en = 1'b1;
                w.ctrl.mul_a  = MA_DIFF;
                w.ctrl.mul_b  = MB_DTIME;
                w.ctrl.acc_op = ACC_ADD_PROD;
            end
            ST_MUL_SCALE:
            begin
                w.ctrl.mul_en = 1'b1;
                w.ctrl.mul_a  = MA_PROD;
                w.ctrl.mul_b  = MB_DSCALE;
            end
            ST_ADD_D:
            begin
                w.ctrl.acc_op = ACC_ADD_PROD;
            end
            ST_MUL_HI:
            begin
                w.ctrl.mul_en = 1'b1;
                w.ctrl.mul_a  = MA_HI;
                w.ctrl.mul_b  = MB_KP;
            end
            ST_MUL_LO:
            begin
                w.ctrl.mul_en = 1'b1;
                w.ctrl.mul_a  = MA_LO;
                w.ctrl.mul_b  = MB_KP;
                w.ctrl.acc_op = ACC_LOAD_SHIFT;
            end
            ST_ADD_LO:
            begin
                w.ctrl.acc_op = ACC_ADD_PROD;
            end
            ST_OUT:
            begin
                w.ctrl.out_load = 1'b1;
                w.jump          = J_OUT_BUSY;
                w.target        = ST_OUT;
            end
            default:
            begin
                w.jump   = J_NEXT;
                w.target = ST_WAIT;
            end
        endcase
        return w;
    endfunction

    // Step register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    // Next step and control word.
    always_comb
    begin
        uword    = ucode(step_reg);
        step_inc = (step_reg == ST_OUT) ? ST_WAIT : step_t'(4'(step_reg + 4'd1));
        unique case (uword.jump)
            J_NO_ITEM:  step_next = status.item_valid ? step_inc : uword.target;
            J_OUT_BUSY: step_next = status.out_busy ? uword.target : step_inc;
            default:    step_next = step_inc;
        endcase
        ctrl          = uword.ctrl;
        ctrl.out_load = uword.ctrl.out_load && !status.out_busy;
    end

endmodule

@@ rtl/core/gpid_datapath.sv @@
// ----------------------------------------------------------------------------
// gpid_datapath
// Controller state, configuration registers, one shared signed multiplier,
// a 64-bit accumulator and the turn output register.
// ----------------------------------------------------------------------------
module gpid_datapath import gpid_pkg::*; (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ctrl_t                       ctrl,
    input  logic                        in_fire,
    input  logic [BRIGHT_W-1:0]         brightness,
    input  logic signed [SPEED_W-1:0]   forward_speed,
    input  logic                        cfg_we,
    input  logic [CFG_INDEX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic signed [TURN_W-1:0]    turn
);

    // Control and configuration state.
    logic [THRESH_W-1:0]       threshold_reg, threshold_next;
    logic [DTIME_W-1:0]        dtime_reg, dtime_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic signed [ERR_W-1:0]   prev_reg, prev_next;
    logic                      out_valid_reg, out_valid_next;

    // Payload registers.
    logic [BRIGHT_W-1:0]       bright_reg, bright_next;
    logic [KEY_W-1:0]          key_reg, key_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic signed [DIFF_W-1:0]  diff_reg, diff_next;
    gain_t                     gain_reg, gain_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [TURN_W-1:0]  turn_reg, turn_next;

    // Intermediate values.
    logic signed [ERR_W:0]     err_wide;
    logic signed [ERR_W-1:0]   err_now;
    logic signed [SUM_W:0]     sum_wide;
    logic signed [SUM_W-1:0]   sum_sat;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_full;
    logic signed [ACC_W-1:0]   prod_ext;
    logic [ACC_W-1:0]          mag;
    logic [ACC_W-FRAC_SHIFT-1:0] mag_int;
    logic [TURN_W-1:0]         lim;

    // Error, saturating error sum and error difference.
    always_comb
    begin
        err_wide = $signed({2'b00, threshold_reg}) - $signed({2'b00, bright_reg});
        err_now  = err_wide[ERR_W-1:0];
        sum_wide = {sum_reg[SUM_W-1], sum_reg}
                 + {{(SUM_W+1-ERR_W){err_now[ERR_W-1]}}, err_now};
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    // Multiplier operand selection and the shared multiplier.
    always_comb
    begin
        case (ctrl.mul_a)
            MA_SUM:  mul_a = {{(MUL_A_W-SUM_W){sum_reg[SUM_W-1]}}, sum_reg};
            MA_DIFF: mul_a = {{(MUL_A_W-DIFF_W){diff_reg[DIFF_W-1]}}, diff_reg};
            MA_PROD: mul_a = {{(MUL_A_W-DTPROD_W){prod_reg[DTPROD_W-1]}},
                              prod_reg[DTPROD_W-1:0]};
            MA_HI:   mul_a = {{(MUL_A_W-INNER_W+LO_W){acc_reg[INNER_W-1]}},
                              acc_reg[INNER_W-1:LO_W]};
            MA_LO:   mul_a = {{(MUL_A_W-LO_W){1'b0}}, acc_reg[LO_W-1:0]};
            default: mul_a = '0;
        endcase
        case (ctrl.mul_b)
            MB_KI:     mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, gain_reg.ki};
            MB_DTIME:  mul_b = {{(MUL_B_W-DTIME_W){1'b0}}, dtime_reg};
            MB_DSCALE: mul_b = MUL_B_W'(DSCALE);
            MB_KP:     mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, gain_reg.kp};
            default:   mul_b = '0;
        endcase
        mul_full = mul_a * mul_b;
        prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    end

    // Turn from the final accumulator: negate, truncate toward zero, clamp.
    always_comb
    begin
        mag     = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        mag_int = mag[ACC_W-1:FRAC_SHIFT];
        if (mag_int > (ACC_W-FRAC_SHIFT)'(TURN_LIMIT))
        begin
            lim = TURN_W'(TURN_LIMIT);
        end
        else
        begin
            lim = mag_int[TURN_W-1:0];
        end
    end

    // Next-state logic.
    always_comb
    begin
        threshold_next = threshold_reg;
        dtime_next     = dtime_reg;
        sum_next       = sum_reg;
        prev_next      = prev_reg;
        out_valid_next = out_valid_reg;
        bright_next    = bright_reg;
        key_next       = key_reg;
        err_next       = err_reg;
        diff_next      = diff_reg;
        gain_next      = gain_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        turn_next      = turn_reg;

        // Configuration writes.
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_LINE_THRESHOLD:  threshold_next = cfg_data[THRESH_W-1:0];
                REG_DERIVATIVE_TIME: dtime_next     = cfg_data[DTIME_W-1:0];
                default:             threshold_next = threshold_reg;
            endcase
        end

        // Capture an accepted sensor word.
        if (in_fire)
        begin
            bright_next = brightness;
            key_next    = gain_select(forward_speed);
        end

        // Controller state update.
        if (ctrl.update)
        begin
            err_next  = err_now;
            diff_next = {err_now[ERR_W-1], err_now} - {prev_reg[ERR_W-1], prev_reg};
            sum_next  = sum_sat;
            prev_next = err_now;
            gain_next = gain_lookup(key_reg);
        end

        if (ctrl.mul_en)
        begin
            prod_next = mul_full;
        end

        case (ctrl.acc_op)
            ACC_LOAD_ERR:   acc_next = {{(ACC_W-ERR_W-ERR_SHIFT){err_reg[ERR_W-1]}}, err_reg,
                                        {ERR_SHIFT{1'b0}}};
            ACC_ADD_PROD:   acc_next = acc_reg + prod_ext;
            ACC_LOAD_SHIFT: acc_next = {prod_ext[ACC_W-LO_W-1:0], {LO_W{1'b0}}};
            default:        acc_next = acc_reg;
        endcase

        // Output register.
        if (ctrl.out_load)
        begin
            out_valid_next = 1'b1;
            turn_next      = acc_reg[ACC_W-1] ? $signed(lim) : $signed(TURN_W'(8'd0 - lim));
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESH_RESET;
            dtime_reg     <= '0;
            sum_reg       <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            threshold_reg <= threshold_next;
            dtime_reg     <= dtime_next;
            sum_reg       <= sum_next;
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        bright_reg <= bright_next;
        key_reg    <= key_next;
        err_reg    <= err_next;
        diff_reg   <= diff_next;
        gain_reg   <= gain_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        turn_reg   <= turn_next;
    end

    assign out_valid = out_valid_reg;
    assign turn      = turn_reg;

endmodule

@@ rtl/core/gain_scheduled_pid_steering.sv @@
// ----------------------------------------------------------------------------
// gain_scheduled_pid_steering
// Line-tracer steering step: PID with speed-scheduled gains, one turn word
// for every sensor word.
// ----------------------------------------------------------------------------
// A sensor word is taken only while the sequencer sits in its wait step. The
// word then runs through nine program steps, five of which issue the single
// shared 26x25 signed multiplier, and its turn lands in the output register;
// the next sensor word can be taken in the cycle after that, so no new word
// is taken before the turn of the last one is loaded. If the previous turn
// is still waiting in the output register, the output step holds until it is
// taken. The user must write configuration through cfg_we/cfg_index/cfg_data
// only while no word is in flight; the block itself does not enforce this.
module gain_scheduled_pid_steering import gpid_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    gpid_sample_if.sink            sensor,
    gpid_turn_if.source            steer
);

    ctrl_t   ctrl;
    status_t status;
    logic    in_fire;

    // Handshake status for the sequencer.
    assign sensor.ready      = ctrl.accept;
    assign in_fire           = sensor.valid && sensor.ready;
    assign status.item_valid = sensor.valid;
    assign status.out_busy   = steer.valid && !steer.ready;

    gpid_sequencer u_sequencer (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    gpid_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .in_fire       (in_fire),
        .brightness    (sensor.brightness),
        .forward_speed (sensor.forward_speed),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_ready     (steer.ready),
        .out_valid     (steer.valid),
        .turn          (steer.turn)
    );

    // The turn never leaves the clamp range.
    a_turn_range: assert property (@(posedge clk) disable iff (!rst_n)
        steer.valid |-> ($signed(steer.turn) <= TURN_LIMIT &&
                         $signed(steer.turn) >= -TURN_LIMIT))
        else $error("turn outside clamp range");

    // Only one word is in flight: no acceptance right after an acceptance.
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !sensor.ready)
        else $error("second word accepted while one is in flight");

    // A loaded result is presented on the next cycle.
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_load |=> steer.valid)
        else $error("loaded result not presented");

endmodule
